/* rtl/query_subscription_match_table_unit_defines.svh */
// assertion macros used by the checker file
`ifndef QUERY_SUBSCRIPTION_MATCH_TABLE_UNIT_DEFINES_SVH
`define QUERY_SUBSCRIPTION_MATCH_TABLE_UNIT_DEFINES_SVH

// property checked outside reset
`define QSMT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("qsmt check failed");

// property checked during reset too
`define QSMT_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("qsmt reset check failed");

`endif

/* rtl/qsmt_pkg.sv */
// ----------------------------------------------------------------------------
// qsmt_pkg
// Types, sizes and codes of the query subscription match table.
// ----------------------------------------------------------------------------
package qsmt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DELIVERED = 3'd5;

    typedef enum logic [1:0] {
        OP_TRACK   = 2'd0,
        OP_UNTRACK = 2'd1,
        OP_EXIT    = 2'd2,
        OP_RESP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_TOP_RD,
        S_TOP_WR,
        S_FINISH
    } t_eng_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] query_key;
        logic [7:0]  block_type;
        logic [7:0]  client_id;
    } t_req_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] dest_client;
        logic       match_flag;
        logic       last;
    } t_result;

    typedef struct packed {
        t_op                 op;
        logic [KEY_BITS-1:0] key;
        logic [7:0]          btype;
        logic [7:0]          client;
    } t_cmd;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [7:0]          btype;
        logic [7:0]          client;
    } t_entry;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_beat;

endpackage

/* rtl/qsmt_front.sv */
// ----------------------------------------------------------------------------
// qsmt_front
// Accepts request beats, decodes them into commands, two-entry queue.
// ----------------------------------------------------------------------------
module qsmt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  qsmt_pkg::t_req_in   i_req,
    output qsmt_pkg::t_cmd_beat o_cmd,
    input  logic                i_cmd_ready
);

    qsmt_pkg::t_cmd r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;
    qsmt_pkg::t_cmd dec;

    // classify the request
    always_comb begin
        dec.op     = qsmt_pkg::t_op'(i_req.req_type);
        dec.key    = i_req.query_key[qsmt_pkg::KEY_BITS-1:0];
        dec.btype  = i_req.block_type;
        dec.client = i_req.client_id;
    end

    assign o_req_ready = (r_cnt != 2'd2);
    assign push        = i_req_valid && o_req_ready;
    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rp];
    assign pop         = o_cmd.valid && i_cmd_ready;

    // pointer and fill update
    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

/* rtl/qsmt_res_queue.sv */
// ----------------------------------------------------------------------------
// qsmt_res_queue
// Two-entry result queue that drives the output channel from registers.
// ----------------------------------------------------------------------------
module qsmt_res_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qsmt_pkg::t_res_beat i_push,
    output logic                o_push_ready,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output qsmt_pkg::t_result   o_res
);

    qsmt_pkg::t_result r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign push         = i_push.valid && o_push_ready;
    assign o_res_valid  = (r_cnt != 2'd0);
    assign o_res        = r_q[r_rp];
    assign pop          = o_res_valid && i_res_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_push.res;
        end
    end

endmodule

/* rtl/qsmt_engine.sv */
// ----------------------------------------------------------------------------
// qsmt_engine
// Table memory and scan sequencer: track, untrack, client exit, response.
// ----------------------------------------------------------------------------
module qsmt_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_wildcard,
    input  qsmt_pkg::t_cmd_beat i_cmd,
    output logic                o_cmd_ready,
    output qsmt_pkg::t_res_beat o_push,
    input  logic                i_push_ready
);

    localparam int IW = qsmt_pkg::IDX_W;
    localparam int CW = qsmt_pkg::CNT_W;

    qsmt_pkg::t_entry     r_mem [qsmt_pkg::TABLE_DEPTH];
    qsmt_pkg::t_entry     r_rd;
    qsmt_pkg::t_eng_state r_state, n_state;
    qsmt_pkg::t_cmd       r_cmd, n_cmd;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_found, n_found;
    logic                 r_hold_v, n_hold_v;
    logic [7:0]           r_hold_cli, n_hold_cli;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    qsmt_pkg::t_entry     wr_data;
    logic [CW-1:0]        cnt_m1;
    logic [IW-1:0]        top_idx;
    logic                 pair_hit, cli_hit, resp_hit;

    assign cnt_m1  = r_cnt - CW'(1);
    assign top_idx = cnt_m1[IW-1:0];

    // compare the entry just read
    assign cli_hit  = (r_rd.client == r_cmd.client);
    assign pair_hit = cli_hit && (r_rd.key == r_cmd.key);
    assign resp_hit = (r_rd.key == r_cmd.key) &&
                      ((r_rd.btype == i_wildcard) || (r_rd.btype == r_cmd.btype));

    // next state and outputs
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_found    = r_found;
        n_hold_v   = r_hold_v;
        n_hold_cli = r_hold_cli;
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = r_rd;
        o_cmd_ready = 1'b0;
        o_push     = '0;

        case (r_state)
            qsmt_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.cmd;
                    n_found  = 1'b0;
                    n_hold_v = 1'b0;
                    n_idx    = top_idx;
                    n_state  = (r_cnt == '0) ? qsmt_pkg::S_FINISH : qsmt_pkg::S_RD;
                end
            end
            qsmt_pkg::S_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_state = qsmt_pkg::S_CMP;
            end
            qsmt_pkg::S_CMP: begin
                // default: step down to the next slot
                if (r_idx == '0) begin
                    n_state = qsmt_pkg::S_FINISH;
                end else begin
                    n_idx   = r_idx - IW'(1);
                    n_state = qsmt_pkg::S_RD;
                end
                case (r_cmd.op)
                    qsmt_pkg::OP_TRACK: begin
                        if (pair_hit) begin
                            n_found = 1'b1;
                            n_idx   = r_idx;
                            n_state = qsmt_pkg::S_FINISH;
                        end
                    end
                    qsmt_pkg::OP_UNTRACK: begin
                        if (pair_hit) begin
                            n_found = 1'b1;
                            n_idx   = r_idx;
                            n_state = qsmt_pkg::S_TOP_RD;
                        end
                    end
                    qsmt_pkg::OP_EXIT: begin
                        if (cli_hit) begin
                            n_idx   = r_idx;
                            n_state = qsmt_pkg::S_TOP_RD;
                        end
                    end
                    default: begin
                        // response: one match held back so the last can be marked
                        if (resp_hit) begin
                            if (r_hold_v) begin
                                o_push.valid           = 1'b1;
                                o_push.res.status      = qsmt_pkg::ST_DELIVERED;
                                o_push.res.dest_client = r_hold_cli;
                                o_push.res.match_flag  = 1'b1;
                                o_push.res.last        = 1'b0;
                                if (i_push_ready) begin
                                    n_hold_cli = r_rd.client;
                                end else begin
                                    n_idx   = r_idx;
                                    n_state = qsmt_pkg::S_CMP;
                                end
                            end else begin
                                n_hold_v   = 1'b1;
                                n_hold_cli = r_rd.client;
                            end
                        end
                    end
                endcase
            end
            qsmt_pkg::S_TOP_RD: begin
                rd_en   = 1'b1;
                rd_addr = top_idx;
                n_state = qsmt_pkg::S_TOP_WR;
            end
            qsmt_pkg::S_TOP_WR: begin
                // move the top entry into the freed slot
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rd;
                n_cnt   = cnt_m1;
                if (r_cmd.op == qsmt_pkg::OP_EXIT && r_idx != '0) begin
                    n_idx   = r_idx - IW'(1);
                    n_state = qsmt_pkg::S_RD;
                end else begin
                    n_state = qsmt_pkg::S_FINISH;
                end
            end
            qsmt_pkg::S_FINISH: begin
                o_push.valid           = 1'b1;
                o_push.res.dest_client = 8'd0;
                o_push.res.match_flag  = 1'b0;
                o_push.res.last        = 1'b1;
                case (r_cmd.op)
                    qsmt_pkg::OP_TRACK: begin
                        if (r_found) begin
                            o_push.res.status = qsmt_pkg::ST_DUPLICATE;
                        end else if (r_cnt == CW'(qsmt_pkg::TABLE_DEPTH)) begin
                            o_push.res.status = qsmt_pkg::ST_FULL;
                        end else begin
                            o_push.res.status = qsmt_pkg::ST_ADDED;
                            if (i_push_ready) begin
                                wr_en          = 1'b1;
                                wr_addr        = r_cnt[IW-1:0];
                                wr_data.key    = r_cmd.key;
                                wr_data.btype  = r_cmd.btype;
                                wr_data.client = r_cmd.client;
                                n_cnt          = r_cnt + CW'(1);
                            end
                        end
                    end
                    qsmt_pkg::OP_UNTRACK: begin
                        o_push.res.status = r_found ? qsmt_pkg::ST_REMOVED
                                                    : qsmt_pkg::ST_NOT_FOUND;
                    end
                    qsmt_pkg::OP_EXIT: begin
                        o_push.res.status = qsmt_pkg::ST_NOT_FOUND;
                    end
                    default: begin
                        if (r_hold_v) begin
                            o_push.res.status      = qsmt_pkg::ST_DELIVERED;
                            o_push.res.dest_client = r_hold_cli;
                            o_push.res.match_flag  = 1'b1;
                        end else begin
                            o_push.res.status = qsmt_pkg::ST_NOT_FOUND;
                        end
                    end
                endcase
                if (i_push_ready) begin
                    n_state = qsmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qsmt_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qsmt_pkg::S_IDLE;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_hold_v <= n_hold_v;
            r_found  <= n_found;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_hold_cli <= n_hold_cli;
    end

    // table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

endmodule

/* rtl/query_subscription_match_table_unit.sv */
// Path: request queue into the engine, then a read and a compare per slot scanned, a top read
// and a top write per removal, the finish state, then the result queue.
// Throughput: one request at a time in the engine, set by the scan over the table.
// Responses give one result per match; the result queue lets the scan run on.
// Reset: synchronous, active low; the table count and queues clear, wildcard is 0.
// ----------------------------------------------------------------------------
// query_subscription_match_table_unit
// Pending query table: track, untrack, client exit and response delivery.
// ----------------------------------------------------------------------------
module query_subscription_match_table_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  qsmt_pkg::t_req_in i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output qsmt_pkg::t_result o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);

    logic [7:0]          r_wildcard;
    qsmt_pkg::t_cmd_beat cmd;
    logic                cmd_ready;
    qsmt_pkg::t_res_beat push;
    logic                push_ready;

    // wildcard type register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wildcard <= 8'd0;
        end else if (i_cfg_valid) begin
            r_wildcard <= i_cfg_data;
        end
    end

    qsmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    qsmt_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wildcard   (r_wildcard),
        .i_cmd        (cmd),
        .o_cmd_ready  (cmd_ready),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    qsmt_res_queue u_res_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (o_res)
    );

endmodule

/* rtl/qsmt_checker.sv */
// ----------------------------------------------------------------------------
// qsmt_checker
// Port-level checks on the result channel of the match table.
// ----------------------------------------------------------------------------
`include "query_subscription_match_table_unit_defines.svh"

module qsmt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_res_valid,
    input logic              i_res_ready,
    input qsmt_pkg::t_result o_res
);

    // a stalled result beat holds
    `QSMT_ASSERT(a_res_hold, o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))

    // match flag goes with delivery status only
    `QSMT_ASSERT(a_flag_status, o_res_valid |-> (o_res.match_flag == (o_res.status == qsmt_pkg::ST_DELIVERED)))

    // a status or no-match beat always closes its run
    `QSMT_ASSERT(a_status_last, o_res_valid && !o_res.match_flag |-> o_res.last)

    // no result beat right after reset
    `QSMT_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_res_valid)

endmodule

bind query_subscription_match_table_unit qsmt_checker u_qsmt_checker (.*);
